### rtl/qrs_pkg.sv
package qrs_pkg;

  localparam int unsigned CoefW = 16;
  localparam int unsigned DiscW = 34;
  localparam int unsigned SqrtW = 26;
  localparam int unsigned RootW = 32;
  localparam int unsigned NumW  = 20;
  localparam int unsigned DivW  = 2;
  localparam int unsigned DenW  = 18;
  localparam int unsigned QW    = NumW + 16;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatNeg  = 2'd1;
  localparam logic [1:0] StatZero = 2'd2;
  localparam logic [1:0] StatSat  = 2'd3;

  // bisection carry state
  typedef struct packed {
    logic [DiscW-1:0] disc;
    logic [DiscW-1:0] lo;
    logic [DiscW-1:0] hi;
    logic [DiscW-1:0] mid;
    logic             done;
    logic [CoefW-1:0] coef_b;
    logic [CoefW-1:0] coef_a;
    logic             func;
    logic [1:0]       status;
  } sqrt_t;

  // long division carry state
  typedef struct packed {
    logic [QW-1:0]   rem;
    logic [QW-1:0]   quo;
    logic [QW-1:0]   num;
    logic [DenW-1:0] den;
    logic            neg;
    logic [1:0]      status;
  } div_t;

endpackage

### rtl/qrs_sqrt_stage.sv
module qrs_sqrt_stage
  import qrs_pkg::*;
(
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t in_i,
  output sqrt_t out_o
);

  sqrt_t st_d, st_q;
  logic [DiscW:0]     sum;
  logic [DiscW-1:0]   m;
  logic [2*SqrtW-1:0] sq;

  // a nonnegative discriminant keeps every midpoint below 2^SqrtW
  always_comb begin
    st_d = in_i;
    sum  = {1'b0, in_i.lo} + {1'b0, in_i.hi};
    m    = sum[DiscW:1];
    sq   = m[SqrtW-1:0] * m[SqrtW-1:0];
    if (!in_i.done) begin
      st_d.mid = m;
      if (sq == {{(2*SqrtW-DiscW){1'b0}}, in_i.disc}) begin
        st_d.done = 1'b1;
      end else if (sq > {{(2*SqrtW-DiscW){1'b0}}, in_i.disc}) begin
        st_d.hi = m;
      end else begin
        st_d.lo = m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule

### rtl/qrs_div_stage.sv
module qrs_div_stage
  import qrs_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  div_t in_i,
  output div_t out_o
);

  div_t st_d, st_q;
  logic [QW-1:0] r;
  logic          bitv;
  integer        k;

  always_comb begin
    st_d = in_i;
    for (k = 0; k < DivW; k++) begin
      r    = {st_d.rem[QW-2:0], st_d.num[QW-1]};
      bitv = r >= {{(QW-DenW){1'b0}}, st_d.den};
      st_d.rem = bitv ? r - {{(QW-DenW){1'b0}}, st_d.den} : r;
      st_d.quo = {st_d.quo[QW-2:0], bitv};
      st_d.num = {st_d.num[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign out_o = st_q;

endmodule

### rtl/quadratic_root_solver_core.sv
// channel | valid       | stall       | payload
// in      | in_valid_i  | in_stall_o  | coef_a_i coef_b_i coef_c_i func_i
// out     | out_valid_o | out_stall_i | root_o status_o
// one transaction per cycle sustained while the output is not stalled
// the bisection takes one stage per step and the 36-bit divide two bits a stage
// the whole pipe advances when the output register is empty or being taken
// reset clears the valid bits only
module quadratic_root_solver_core
  import qrs_pkg::*;
#(
  parameter int SQRT_STEPS = 17
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [CoefW-1:0] coef_a_i,
  input  logic signed [CoefW-1:0] coef_b_i,
  input  logic signed [CoefW-1:0] coef_c_i,
  input  logic                    func_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [RootW-1:0] root_o,
  output logic [1:0]              status_o
);

  localparam int DivStages = QW / DivW;
  localparam int Depth     = SQRT_STEPS + DivStages + 3;

  logic adv;
  logic [Depth-1:0] vld_q;

  assign adv        = !vld_q[Depth-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // stage 0: products
  logic signed [31:0] bb_q, ac_q;
  logic [CoefW-1:0] a0_q, b0_q;
  logic f0_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q <= coef_b_i * coef_b_i;
      ac_q <= coef_a_i * coef_c_i;
      a0_q <= coef_a_i;
      b0_q <= coef_b_i;
      f0_q <= func_i;
    end
  end

  // stage 1: discriminant and bisection setup
  logic signed [DiscW:0] disc;
  sqrt_t s_init;
  sqrt_t s_q;
  always_comb begin
    disc = {{3{bb_q[31]}}, bb_q} - {ac_q[31], ac_q, 2'b00};
    s_init.disc   = disc[DiscW-1:0];
    s_init.lo     = '0;
    s_init.hi     = (disc[DiscW-1:8] < 26'd256) ? DiscW'(256)
                  : {8'd0, disc[DiscW-1:8]};
    s_init.mid    = '0;
    s_init.done   = 1'b0;
    s_init.coef_b = b0_q;
    s_init.coef_a = a0_q;
    s_init.func   = f0_q;
    s_init.status = disc[DiscW] ? StatNeg : (a0_q == '0) ? StatZero : StatOk;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_init;
    end
  end

  sqrt_t s_pipe [SQRT_STEPS+1];
  assign s_pipe[0] = s_q;
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    qrs_sqrt_stage u_stage (
      .clk_i (clk_i),
      .en_i  (adv),
      .in_i  (s_pipe[g]),
      .out_o (s_pipe[g+1])
    );
  end

  // divide setup on magnitudes
  // with eight or more steps the last midpoint stays below 2^18
  sqrt_t s_end;
  logic signed [NumW-1:0] num;
  logic [NumW-1:0] num_mag;
  logic signed [DenW-1:0] den;
  logic [DenW-1:0] den_mag;
  div_t d_init;
  assign s_end = s_pipe[SQRT_STEPS];
  always_comb begin
    num = s_end.func
        ? -NumW'(signed'(s_end.coef_b)) + NumW'(s_end.mid[17:0])
        : -NumW'(signed'(s_end.coef_b)) - NumW'(s_end.mid[17:0]);
    den     = {s_end.coef_a[CoefW-1], s_end.coef_a, 1'b0};
    num_mag = num[NumW-1] ? -num : num;
    den_mag = den[DenW-1] ? -den : den;
    d_init.rem    = '0;
    d_init.quo    = '0;
    d_init.num    = {num_mag, 16'd0};
    d_init.den    = den_mag;
    d_init.neg    = num[NumW-1] ^ den[DenW-1];
    d_init.status = s_end.status;
  end

  div_t d_pipe [DivStages+1];
  assign d_pipe[0] = d_init;
  for (genvar g = 0; g < DivStages; g++) begin : g_div
    qrs_div_stage u_stage (
      .clk_i (clk_i),
      .en_i  (adv),
      .in_i  (d_pipe[g]),
      .out_o (d_pipe[g+1])
    );
  end

  // sign, clamp, output register
  div_t d_end;
  logic signed [QW:0] q;
  logic signed [RootW-1:0] root_d, root_q;
  logic [1:0] stat_d, stat_q;
  assign d_end = d_pipe[DivStages];
  always_comb begin
    q = d_end.neg ? -signed'({1'b0, d_end.quo}) : signed'({1'b0, d_end.quo});
    stat_d = d_end.status;
    root_d = '0;
    if (d_end.status == StatOk) begin
      if (q > signed'((QW+1)'(32'h7fffffff))) begin
        root_d = 32'sh7fffffff;
        stat_d = StatSat;
      end else if (q < -signed'((QW+1)'(33'h80000000))) begin
        root_d = 32'sh80000000;
        stat_d = StatSat;
      end else begin
        root_d = q[RootW-1:0];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      root_q <= root_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign root_o      = root_q;
  assign status_o    = stat_q;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(root_o) && $stable(status_o));
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o);
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatNeg || status_o == StatZero) |-> root_o == '0);
`endif

endmodule

### dv/quadratic_root_solver_core_tb.sv
module quadratic_root_solver_core_tb
  import qrs_pkg::*;
();

  localparam int SqrtSteps = 17;
  localparam int Latency   = 3 + SqrtSteps + QW / DivW;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic               sel;
  } coef_set_t;

  typedef struct {
    logic signed [31:0] root;
    logic [1:0]         status;
  } root_res_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic signed [CoefW-1:0] coef_a_i = '0;
  logic signed [CoefW-1:0] coef_b_i = '0;
  logic signed [CoefW-1:0] coef_c_i = '0;
  logic                    func_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [RootW-1:0] root_o;
  logic [1:0]              status_o;

  coef_set_t pending_sets[$];
  root_res_t expected_roots[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;
  bit        stim_done = 1'b0;
  bit        in_taken = 1'b0;

  quadratic_root_solver_core #(.SQRT_STEPS(SqrtSteps)) i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned isqrt_bisect(longint unsigned disc);
    longint unsigned lo, hi, mid, sq;
    lo = 0;
    hi = disc >> 8;
    mid = 0;
    if (hi < 256) hi = 256;
    for (int k = 0; k < SqrtSteps; k++) begin
      mid = (lo + hi) >> 1;
      sq = mid * mid;
      if (sq == disc) break;
      if (sq > disc) hi = mid;
      else lo = mid;
    end
    return mid;
  endfunction

  function automatic root_res_t solve_root(coef_set_t s);
    root_res_t r;
    longint disc, d, num, q;
    disc = longint'(s.b) * s.b - 4 * longint'(s.a) * s.c;
    r.root = '0;
    r.status = StatOk;
    if (disc < 0) begin
      r.status = StatNeg;
      return r;
    end
    if (s.a == 0) begin
      r.status = StatZero;
      return r;
    end
    d = longint'(isqrt_bisect(longint'(disc)));
    num = s.sel ? (-longint'(s.b) + d) : (-longint'(s.b) - d);
    q = (num * 65536) / (2 * longint'(s.a));
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      r.status = StatSat;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      r.status = StatSat;
    end
    r.root = q[31:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1024)) - 512);
      2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 8'($urandom)};
      3: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  task automatic add_set(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic sel);
    coef_set_t s;
    s.a = a;
    s.b = b;
    s.c = c;
    s.sel = sel;
    pending_sets.push_back(s);
  endtask

  initial begin
    for (int f = 0; f < 2; f++) begin
      add_set(16'h0100, 16'hfd00, 16'h0200, f);  // x^2 - 3x + 2
      add_set(16'h0100, 16'h0000, 16'h0100, f);  // negative discriminant
      add_set(16'h0000, 16'h0300, 16'h0100, f);  // a is zero
      add_set(16'h0001, 16'h7fff, 16'h0000, f);  // saturation on the minus root (f = 0)
      add_set(16'hffff, 16'h8000, 16'h0000, f);
      add_set(16'h7fff, 16'h7fff, 16'h8000, f);
      add_set(16'h8000, 16'h8000, 16'h7fff, f);
      add_set(16'h8000, 16'h7fff, 16'h8000, f);
      add_set(16'h0100, 16'h0000, 16'h0000, f);  // zero discriminant
      add_set(16'h0001, 16'h0001, 16'h0000, f);  // tiny discriminant
      add_set(16'hffff, 16'hffff, 16'hffff, f);
    end
    for (int i = 0; i < 1000; i++) begin
      add_set(rand_coef(), rand_coef(), rand_coef(), 1'($urandom));
    end
    stim_done = 1'b1;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: bursts separated by random gaps
  // in_taken records acceptance at the last rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_sets.size() > 0) begin
          coef_set_t s;
          s = pending_sets.pop_front();
          coef_a_i <= s.a;
          coef_b_i <= s.b;
          coef_c_i <= s.c;
          func_i <= s.sel;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (cycles % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        coef_set_t s;
        s.a = coef_a_i;
        s.b = coef_b_i;
        s.c = coef_c_i;
        s.sel = func_i;
        expected_roots.push_back(solve_root(s));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction root=%0d status=%0d",
                                         root_o, status_o);
        end else begin
          root_res_t e;
          e = expected_roots.pop_front();
          if (e.root !== root_o || e.status !== status_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected root=%0d status=%0d, got root=%0d status=%0d",
                       e.root, e.status, root_o, status_o);
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done && rst_ni);
    while ((pending_sets.size() > 0 || in_valid_i || expected_roots.size() > 0)
           && cycles < CycleLimit)
      @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (cycles >= CycleLimit) begin
      $display("quadratic_root_solver_core verification failed");
    end else if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_core verification clean");
    end else begin
      $display("quadratic_root_solver_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/qrs_pkg.sv
rtl/qrs_sqrt_stage.sv
rtl/qrs_div_stage.sv
rtl/quadratic_root_solver_core.sv
dv/quadratic_root_solver_core_tb.sv
